### design/iesc_pkg.sv
// Package for the infix expression syntax checker.
// Holds byte classes, status codes, the token record and the class/judge functions.
// No dependencies.
`default_nettype none

package iesc_pkg;

    typedef logic [2:0] t_cls;
    typedef logic [3:0] t_status;

    localparam t_cls CLS_BOUNDARY = 3'd0;
    localparam t_cls CLS_DIGIT    = 3'd1;
    localparam t_cls CLS_OPERATOR = 3'd2;
    localparam t_cls CLS_OPEN     = 3'd3;
    localparam t_cls CLS_CLOSE    = 3'd4;
    localparam t_cls CLS_OTHER    = 3'd5;

    localparam t_status ST_OK            = 4'd0;
    localparam t_status ST_START_OP      = 4'd1;
    localparam t_status ST_END_OP        = 4'd2;
    localparam t_status ST_ADJ_OP        = 4'd3;
    localparam t_status ST_OP_NO_OPERAND = 4'd4;
    localparam t_status ST_NO_OP_OPEN    = 4'd5;
    localparam t_status ST_BAD_AFTER_OPN = 4'd6;
    localparam t_status ST_BAD_BEFORE_CL = 4'd7;
    localparam t_status ST_NO_OP_CLOSE   = 4'd8;
    localparam t_status ST_NO_OP_NUMBER  = 4'd9;
    localparam t_status ST_NO_OP_BETWEEN = 4'd10;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    // Record passed from front to back through the queue.
    typedef struct packed {
        logic has_tok;   // byte starts a new token
        t_cls cls;       // class of that token
        logic is_last;   // closes the expression
    } t_tok;

    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        c = CLS_OTHER;
        if (b == CH_NUL) begin
            c = CLS_BOUNDARY;
        end else if (b inside {[8'h30:8'h39]}) begin
            c = CLS_DIGIT;
        end else if (b inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5E}) begin
            c = CLS_OPERATOR;
        end else if (b == CH_OPEN) begin
            c = CLS_OPEN;
        end else if (b == CH_CLOSE) begin
            c = CLS_CLOSE;
        end
        return c;
    endfunction

    function automatic t_status judge(input t_cls bef, input t_cls tok, input t_cls nxt);
        t_status e;
        e = ST_OK;
        case (tok)
            CLS_OPERATOR: begin
                if (bef == CLS_BOUNDARY)                            e = ST_START_OP;
                else if (nxt == CLS_BOUNDARY)                       e = ST_END_OP;
                else if (bef == CLS_OPERATOR || nxt == CLS_OPERATOR) e = ST_ADJ_OP;
                else if (bef == CLS_OPEN || nxt == CLS_CLOSE)       e = ST_OP_NO_OPERAND;
            end
            CLS_OPEN: begin
                if (bef == CLS_DIGIT || bef == CLS_CLOSE)           e = ST_NO_OP_OPEN;
                else if (nxt == CLS_OPERATOR || nxt == CLS_CLOSE)   e = ST_BAD_AFTER_OPN;
            end
            CLS_CLOSE: begin
                if (bef == CLS_OPERATOR || bef == CLS_OPEN)         e = ST_BAD_BEFORE_CL;
                else if (nxt == CLS_DIGIT || nxt == CLS_OPEN)       e = ST_NO_OP_CLOSE;
            end
            CLS_DIGIT: begin
                if (bef == CLS_CLOSE)                               e = ST_NO_OP_NUMBER;
                else if (nxt == CLS_OPEN)                           e = ST_NO_OP_OPEN;
                else if (nxt == CLS_DIGIT)                          e = ST_NO_OP_BETWEEN;
            end
            default: e = ST_OK;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

### design/iesc_if.sv
// Valid/ready channel interfaces of the syntax checker.
// Depends on iesc_pkg for the status type.
`default_nettype none

interface iesc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       is_last;

    modport source (output valid, output char_byte, output is_last, input ready);
    modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

interface iesc_out_if
    import iesc_pkg::*;
;
    logic    valid;
    logic    ready;
    t_status status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

### design/iesc_front.sv
// Front end: accepts bytes, skips spaces, merges digit runs into one token.
// Depends on iesc_pkg; pushes t_tok records into the queue.
`default_nettype none

module iesc_front
    import iesc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    iesc_in_if.sink    i_in,
    input  wire        i_q_full,
    output logic       o_q_push,
    output t_tok       o_q_data
);

    logic r_last_digit;
    logic n_last_digit;
    logic accept;
    logic is_space;
    t_cls cls;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign is_space   = (i_in.char_byte == CH_SPACE);
    assign cls        = classify(i_in.char_byte);

    always_comb begin
        o_q_data.cls     = cls;
        o_q_data.is_last = i_in.is_last;
        o_q_data.has_tok = !is_space && !(cls == CLS_DIGIT && r_last_digit);
        // Bytes inside a number or spaces mid-expression carry nothing for the back end.
        o_q_push         = accept && (o_q_data.has_tok || i_in.is_last);

        n_last_digit = r_last_digit;
        if (accept) begin
            if (i_in.is_last) n_last_digit = 1'b0;
            else              n_last_digit = !is_space && (cls == CLS_DIGIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_digit <= 1'b0;
        end else begin
            r_last_digit <= n_last_digit;
        end
    end

endmodule

`default_nettype wire

### design/iesc_fifo.sv
// Short token queue between front and back end.
// Depends on iesc_pkg for the t_tok record.
`default_nettype none

module iesc_fifo
    import iesc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_tok i_data,
    output logic o_full,
    input  wire  i_pop,
    output logic o_empty,
    output t_tok o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_tok          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (do_pop)  n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (do_push && !do_pop)      n_cnt = r_cnt + 1'b1;
        else if (do_pop && !do_push) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

### design/iesc_back.sv
// Back end: judges each token against its neighbors, keeps the first error,
// and holds the status in an output register. Depends on iesc_pkg, iesc_if.
`default_nettype none

module iesc_back
    import iesc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_q_empty,
    input  t_tok        i_q_data,
    output logic        o_q_pop,
    iesc_out_if.source  o_out
);

    t_cls    r_before;
    t_cls    r_pend;
    logic    r_pend_vld;
    t_status r_err;
    logic    r_out_vld;
    t_status r_status;

    t_cls    n_before;
    t_cls    n_pend;
    logic    n_pend_vld;
    t_status n_err;
    logic    n_out_vld;
    t_status n_status;

    t_status e_next;
    t_status e_end;
    t_status err_a;
    t_cls    before_a;
    t_cls    pend_a;
    logic    vld_a;

    assign o_out.valid  = r_out_vld;
    assign o_out.status = r_status;

    // A closing entry needs room in the output register; others always drain.
    assign o_q_pop = !i_q_empty && (!i_q_data.is_last || !r_out_vld || o_out.ready);

    always_comb begin
        // settle the pending token against the new one
        e_next   = (r_pend_vld && i_q_data.has_tok) ? judge(r_before, r_pend, i_q_data.cls)
                                                    : ST_OK;
        err_a    = (r_err != ST_OK) ? r_err : e_next;
        before_a = i_q_data.has_tok ? (r_pend_vld ? r_pend : CLS_BOUNDARY) : r_before;
        pend_a   = i_q_data.has_tok ? i_q_data.cls : r_pend;
        vld_a    = i_q_data.has_tok || r_pend_vld;
        // end of expression: settle against the boundary
        e_end    = vld_a ? judge(before_a, pend_a, CLS_BOUNDARY) : ST_OK;

        n_before   = r_before;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_err      = r_err;
        n_out_vld  = r_out_vld && !o_out.ready;
        n_status   = r_status;

        if (o_q_pop) begin
            if (i_q_data.is_last) begin
                n_before   = CLS_BOUNDARY;
                n_pend     = CLS_BOUNDARY;
                n_pend_vld = 1'b0;
                n_err      = ST_OK;
                n_out_vld  = 1'b1;
                n_status   = (err_a != ST_OK) ? err_a : e_end;
            end else begin
                n_before   = before_a;
                n_pend     = pend_a;
                n_pend_vld = vld_a;
                n_err      = err_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_before   <= CLS_BOUNDARY;
            r_pend     <= CLS_BOUNDARY;
            r_pend_vld <= 1'b0;
            r_err      <= ST_OK;
            r_out_vld  <= 1'b0;
        end else begin
            r_before   <= n_before;
            r_pend     <= n_pend;
            r_pend_vld <= n_pend_vld;
            r_err      <= n_err;
            r_out_vld  <= n_out_vld;
        end
    end

endmodule

`default_nettype wire

### design/infix_expression_syntax_checker.sv
// Infix expression syntax checker. Takes one byte of an expression per item on
// i_in (is_last marks the final byte) and returns one status item on o_out per
// expression: 0 when valid, else the code of the first violation found. Spaces
// are skipped, a run of adjacent digits is one number, and every other byte is
// a token judged against its non-space neighbors; byte 0 acts as a boundary.
// Parenthesis balance is not checked. With QUEUE_DEPTH >= 2, throughput is
// one byte per cycle: the front end classifies a byte in the cycle it is
// accepted and the back end retires one queued token per cycle. The last byte
// passes the token queue, then the output register. The input stalls only when
// the queue fills, at that depth only while a finished status sits unread.
// Depends on iesc_pkg, iesc_if, iesc_front, iesc_fifo, iesc_back.
`default_nettype none

module infix_expression_syntax_checker
    import iesc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2   // token queue entries, at least 1
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    iesc_in_if.sink     i_in,
    iesc_out_if.source  o_out
);

    // front -> queue
    logic q_push;
    logic q_full;
    t_tok q_wdata;
    // queue -> back
    logic q_pop;
    logic q_empty;
    t_tok q_rdata;

    // Classifier: drops spaces and the tail of numbers, so only token
    // starts and end markers occupy the queue.
    iesc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    // Decouples the input from output back-pressure.
    iesc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    // Rule checker with the first-error register and output register.
    iesc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
